// ----- src/bsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared widths, types and controller/datapath handshake structs for the
// boundary strength profile unit.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int INDEX_BITS = 16;
  localparam int CHG_BITS   = FRAC_BITS + 1;
  localparam int SUM_BITS   = FRAC_BITS + 2;
  localparam int STR_BITS   = 32;
  localparam int PROD_BITS  = VALUE_BITS - 1 + SUM_BITS;
  localparam int DIV_STEPS  = CHG_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CHG_BITS-1:0]          chg_t;
  typedef logic [INDEX_BITS-1:0]        idx_t;
  typedef logic [STR_BITS-1:0]          str_t;

  typedef struct packed {
    logic load_in;
    logic div_step;
    logic emit_held;
    logic emit_own;
    logic update_hold;
  } bsp_cmd_t;

  typedef struct packed {
    logic have_pending;
    logic cur_last;
    logic out_free;
  } bsp_status_t;

endpackage

// ----- src/bsp_in_if.sv -----
// ----------------------------------------------------------------------------
// bsp_in_if
// Request channel carrying one profile entry.
// ----------------------------------------------------------------------------
interface bsp_in_if;
  logic                  valid;
  logic                  ready;
  logic signed [15:0]    profile_value;
  logic                  is_final;

  modport source (output valid, output profile_value, output is_final, input ready);
  modport sink   (input valid, input profile_value, input is_final, output ready);
endinterface

// ----- src/bsp_out_if.sv -----
// ----------------------------------------------------------------------------
// bsp_out_if
// Result channel carrying one boundary strength result.
// ----------------------------------------------------------------------------
interface bsp_out_if;
  logic                  valid;
  logic                  ready;
  logic [15:0]           element_index;
  logic signed [15:0]    entry_value;
  logic [16:0]           change_degree;
  logic [31:0]           strength;
  logic                  end_of_profile;

  modport source (output valid, output element_index, output entry_value,
                  output change_degree, output strength, output end_of_profile,
                  input ready);
  modport sink   (input valid, input element_index, input entry_value,
                  input change_degree, input strength, input end_of_profile,
                  output ready);
endinterface

// ----- src/boundary_strength_profile_unit.sv -----
// ----------------------------------------------------------------------------
// boundary_strength_profile_unit
// Boundary strength of each entry of a stream of profiles.
//
// items (sink): one signed profile value per request, is_final marks the
//   last entry of a profile.
// results (source): index, value, change degree (Q1.16), strength (16
//   fraction bits) and end_of_profile. An entry's result leaves when the
//   next entry of its profile arrives; the last entry gives two results.
// Sequence: an entry is accepted, run through the restoring divider steps
//   and multiplied for its results; no new entry is taken until it is
//   through. The 17-bit serial divider computes the change ratio.
// Order: a held result is registered once the entry that releases it is
//   divided, a last entry's own result after that, from S_OWN.
// Stall: a result waits in the output register while the next entry is
//   accepted and divided; the unit holds only when a new result is due
//   and the output register has not been emptied yet.
// Reset: synchronous, clears the held entry, so the next entry starts a new
//   profile at index 0; no result is pending.
// ----------------------------------------------------------------------------
module boundary_strength_profile_unit (
  input  logic       clk,
  input  logic       rst,
  bsp_in_if.sink     items,
  bsp_out_if.source  results
);
  import bsp_pkg::*;

  bsp_cmd_t    cmd;
  bsp_status_t status;

  bsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bsp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .profile_value  (items.profile_value),
    .is_final       (items.is_final),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .element_index  (results.element_index),
    .entry_value    (results.entry_value),
    .change_degree  (results.change_degree),
    .strength       (results.strength),
    .end_of_profile (results.end_of_profile)
  );

endmodule

// ----- src/bsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsp_ctrl
// Sequencer: accepts an entry, runs the serial divider, then emits the held
// result and, on the last entry, the entry's own result.
// ----------------------------------------------------------------------------
module bsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bsp_pkg::bsp_status_t status,
  output bsp_pkg::bsp_cmd_t    cmd
);
  import bsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_HELD = 4'b0100,
    S_OWN  = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          count_next  = '0;
          state_next  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (count == CNT_BITS'(DIV_STEPS - 1)) begin
          state_next = S_HELD;
        end else begin
          count_next = count + 1'b1;
        end
      end
      S_HELD: begin
        // nothing held means nothing to emit, so no need to wait on the output
        if (!status.have_pending || status.out_free) begin
          cmd.emit_held = status.have_pending;
          if (status.cur_last) begin
            state_next = S_OWN;
          end else begin
            cmd.update_hold = 1'b1;
            state_next      = S_IDLE;
          end
        end
      end
      S_OWN: begin
        if (status.out_free) begin
          cmd.emit_own    = 1'b1;
          cmd.update_hold = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/bsp_datapath.sv -----
// ----------------------------------------------------------------------------
// bsp_datapath
// Entry registers, restoring divider for the change ratio, held entry,
// shared strength multiplier and output register.
// ----------------------------------------------------------------------------
module bsp_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bsp_pkg::value_t      profile_value,
  input  logic                 is_final,
  input  bsp_pkg::bsp_cmd_t    cmd,
  output bsp_pkg::bsp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bsp_pkg::idx_t        element_index,
  output bsp_pkg::value_t      entry_value,
  output bsp_pkg::chg_t        change_degree,
  output bsp_pkg::str_t        strength,
  output logic                 end_of_profile
);
  import bsp_pkg::*;

  localparam int MAG_BITS = VALUE_BITS - 1;

  value_t                cur_value;
  logic                  cur_last;
  logic [VALUE_BITS-1:0] sum;
  logic [VALUE_BITS-1:0] rem;
  logic [CHG_BITS-1:0]   dvd;
  chg_t                  quot;
  logic                  zero_r;

  value_t                held_value;
  chg_t                  held_change;
  idx_t                  held_index;
  logic                  have_pending;

  value_t                prev;
  logic [MAG_BITS-1:0]   prev_mag, x_mag, diff;
  logic [VALUE_BITS-1:0] sum_in;
  logic [VALUE_BITS:0]   shifted;
  logic                  q_bit;
  chg_t                  r;
  idx_t                  own_idx;
  value_t                mul_x;
  logic [SUM_BITS-1:0]   mul_c;
  logic [MAG_BITS-1:0]   mul_mag;
  logic [PROD_BITS-1:0]  prod;
  str_t                  str_sat;

  // operands of the ratio, predecessor is zero at the start of a profile
  always_comb begin
    prev     = have_pending ? held_value : '0;
    prev_mag = prev[MAG_BITS-1:0];
    x_mag    = profile_value[MAG_BITS-1:0];
    sum_in   = {1'b0, prev_mag} + {1'b0, x_mag};
    diff     = (prev_mag >= x_mag) ? (prev_mag - x_mag) : (x_mag - prev_mag);
  end

  // one restoring step: quotient of (diff << FRAC_BITS) / sum, msb first
  always_comb begin
    shifted = {rem, dvd[CHG_BITS-1]};
    q_bit   = (shifted >= {1'b0, sum});
  end

  assign r = zero_r ? '0 : quot;

  always_comb begin
    if (!have_pending) begin
      own_idx = '0;
    end else if (&held_index) begin
      own_idx = held_index;
    end else begin
      own_idx = held_index + 1'b1;
    end
  end

  // shared multiplier, negative entries always carry a zero change sum
  always_comb begin
    mul_x   = cmd.emit_own ? cur_value : held_value;
    mul_c   = cmd.emit_own ? SUM_BITS'(r)
                           : (SUM_BITS'(held_change) + SUM_BITS'(r));
    mul_mag = mul_x[VALUE_BITS-1] ? '0 : mul_x[MAG_BITS-1:0];
    prod    = PROD_BITS'(mul_mag) * PROD_BITS'(mul_c);
    str_sat = (|prod[PROD_BITS-1:STR_BITS]) ? '1 : prod[STR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_value <= profile_value;
      cur_last  <= is_final;
      sum       <= sum_in;
      zero_r    <= prev[VALUE_BITS-1] | profile_value[VALUE_BITS-1] | (sum_in == '0);
      rem       <= VALUE_BITS'(diff >> 1);
      dvd       <= {diff[0], FRAC_BITS'(0)};
    end else if (cmd.div_step) begin
      rem  <= q_bit ? VALUE_BITS'(shifted - {1'b0, sum}) : shifted[VALUE_BITS-1:0];
      dvd  <= {dvd[CHG_BITS-2:0], 1'b0};
      quot <= {quot[CHG_BITS-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_pending <= 1'b0;
      held_value   <= '0;
      held_change  <= '0;
      held_index   <= '0;
    end else if (cmd.update_hold) begin
      if (cur_last) begin
        have_pending <= 1'b0;
        held_value   <= '0;
        held_change  <= '0;
        held_index   <= '0;
      end else begin
        have_pending <= 1'b1;
        held_value   <= cur_value;
        held_change  <= r;
        held_index   <= own_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_held || cmd.emit_own) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_held) begin
      element_index  <= held_index;
      entry_value    <= held_value;
      change_degree  <= held_change;
      strength       <= str_sat;
      end_of_profile <= 1'b0;
    end else if (cmd.emit_own) begin
      element_index  <= own_idx;
      entry_value    <= cur_value;
      change_degree  <= r;
      strength       <= str_sat;
      end_of_profile <= 1'b1;
    end
  end

  always_comb begin
    status.have_pending = have_pending;
    status.cur_last     = cur_last;
    status.out_free     = !out_valid || out_ready;
  end

endmodule
